// ===== src/olist_pkg.sv =====
package olist_pkg;

  // Storage geometry of the list.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Widths that follow from the geometry.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result.
  localparam int KIND_W  = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int LIM_W   = 5;

  // Width used for range checks, wide enough for counts, positions and limits.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd2;

  // Limit register value after reset.
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] removed_value;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          list_length;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step_up;
    logic step_down;
    logic wr_move_up;
    logic wr_move_down;
    logic wr_word;
    logic cap_removed;
    logic cnt_inc;
    logic cnt_dec;
    logic loc_check;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ins_ok;
    logic              del_ok;
    logic              append;
    logic              empty;
    logic              at_idx;
    logic              at_last;
    logic              match;
  } dp_status_t;

endpackage

// ===== src/ordered_list_insert_delete_locate.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_req (kind, position, value)
// out      output     out_valid/out_stall out_rsp (ok, removed_value, found_position,
//                                         list_length)
// cfg      input      cfg_wr_en           cfg_wr_data (capacity limit)
//
// One request at a time, moving one entry per cycle through the store's ports: insert
// shifts entries p..n one place up, or only writes the word when it appends; delete
// reads entry p and shifts later ones down; locate scans upward to the first match.
// A rejected request or a locate on an empty list goes straight to the result.
// Reset clears the entry count and sets the limit to 16; stored entries are not
// cleared. While the result is stalled, no new request is taken.
module ordered_list_insert_delete_locate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  olist_pkg::in_req_t          in_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output olist_pkg::out_rsp_t         out_rsp,
  input  logic                        cfg_wr_en,
  input  logic [olist_pkg::LIM_W-1:0] cfg_wr_data
);

  import olist_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer for the request walk.
  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Entry store, count, limit and result registers.
  olist_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_rsp     (out_rsp)
  );

endmodule

// ===== src/olist_ram.sv =====
module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/olist_ctrl.sv =====
module olist_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  olist_pkg::dp_status_t st,
  output olist_pkg::dp_cmd_t    cmd
);

  import olist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_FIRST,
    S_INS_RD,
    S_INS_TAIL,
    S_INS_WORD,
    S_DEL_FIRST,
    S_DEL_ONLY,
    S_DEL_SECOND,
    S_DEL_RD,
    S_DEL_TAIL,
    S_LOC_FIRST,
    S_LOC_RD,
    S_LOC_LAST,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // Handshake decode.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESULT);

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (st.kind)
            KIND_INSERT: begin
              if (!st.ins_ok) begin
                state_nxt = S_RESULT;
              end else if (st.append) begin
                state_nxt = S_INS_WORD;
              end else begin
                state_nxt = S_INS_FIRST;
              end
            end
            KIND_DELETE: begin
              state_nxt = st.del_ok ? S_DEL_FIRST : S_RESULT;
            end
            KIND_LOCATE: begin
              state_nxt = st.empty ? S_RESULT : S_LOC_FIRST;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      // Insert reads from the top entry down and writes each one place higher.
      S_INS_FIRST: begin
        if (st.at_idx) begin
          state_nxt = S_INS_TAIL;
        end else begin
          cmd.step_down = 1'b1;
          state_nxt     = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.wr_move_up = 1'b1;
        if (st.at_idx) begin
          state_nxt = S_INS_TAIL;
        end else begin
          cmd.step_down = 1'b1;
        end
      end
      S_INS_TAIL: begin
        cmd.wr_move_up = 1'b1;
        state_nxt      = S_INS_WORD;
      end
      S_INS_WORD: begin
        cmd.wr_word = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_RESULT;
      end
      // Delete reads the removed entry, then moves later entries one place down.
      S_DEL_FIRST: begin
        cmd.step_up = 1'b1;
        state_nxt   = st.at_last ? S_DEL_ONLY : S_DEL_SECOND;
      end
      S_DEL_ONLY: begin
        cmd.cap_removed = 1'b1;
        cmd.cnt_dec     = 1'b1;
        state_nxt       = S_RESULT;
      end
      S_DEL_SECOND: begin
        cmd.cap_removed = 1'b1;
        if (st.at_last) begin
          state_nxt = S_DEL_TAIL;
        end else begin
          cmd.step_up = 1'b1;
          state_nxt   = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        cmd.wr_move_down = 1'b1;
        if (st.at_last) begin
          state_nxt = S_DEL_TAIL;
        end else begin
          cmd.step_up = 1'b1;
        end
      end
      S_DEL_TAIL: begin
        cmd.wr_move_down = 1'b1;
        cmd.cnt_dec      = 1'b1;
        state_nxt        = S_RESULT;
      end
      // Locate scans upward and stops at the first match.
      S_LOC_FIRST: begin
        if (st.at_last) begin
          state_nxt = S_LOC_LAST;
        end else begin
          cmd.step_up = 1'b1;
          state_nxt   = S_LOC_RD;
        end
      end
      S_LOC_RD: begin
        cmd.loc_check = 1'b1;
        if (st.match) begin
          state_nxt = S_RESULT;
        end else if (st.at_last) begin
          state_nxt = S_LOC_LAST;
        end else begin
          cmd.step_up = 1'b1;
        end
      end
      S_LOC_LAST: begin
        cmd.loc_check = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/olist_dp.sv =====
module olist_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  olist_pkg::in_req_t                      in_req,
  input  logic                                    cfg_wr_en,
  input  logic [olist_pkg::LIM_W-1:0]             cfg_wr_data,
  input  olist_pkg::dp_cmd_t                      cmd,
  output olist_pkg::dp_status_t                   st,
  output olist_pkg::out_rsp_t                     out_rsp
);

  import olist_pkg::*;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [LIM_W-1:0]          lim_r, lim_nxt;
  logic [KIND_W-1:0]         kind_r, kind_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0]     word_r, word_nxt;
  logic [IDX_W-1:0]          addr_r, addr_nxt;
  logic [IDX_W-1:0]          prev_r;
  logic                      ok_r, ok_nxt;
  logic signed [VALUE_W-1:0] removed_r, removed_nxt;
  logic [POS_W-1:0]          found_r, found_nxt;

  logic [CMP_W-1:0]      pos_w, cnt_w, lim_w, lim_eff;
  logic [IDX_W-1:0]      last_idx;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Range checks on the incoming request.
  assign pos_w    = CMP_W'(in_req.position);
  assign cnt_w    = CMP_W'(cnt_r);
  assign lim_w    = CMP_W'(lim_r);
  assign lim_eff  = (lim_w > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : lim_w;
  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));

  assign st.kind    = in_req.kind;
  assign st.ins_ok  = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) && (cnt_w < lim_eff);
  assign st.del_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign st.append  = (pos_w == cnt_w + CMP_W'(1));
  assign st.empty   = (cnt_r == '0);
  assign st.at_idx  = (addr_r == idx_r);
  assign st.at_last = (addr_r == last_idx);
  assign st.match   = (ram_rdata == word_r);

  // Entry store write port: moved entries or the inserted word.
  always_comb begin
    ram_we    = cmd.wr_move_up | cmd.wr_move_down | cmd.wr_word;
    ram_wdata = ram_rdata;
    ram_waddr = prev_r + IDX_W'(1);
    if (cmd.wr_move_down) begin
      ram_waddr = prev_r - IDX_W'(1);
    end else if (cmd.wr_word) begin
      ram_waddr = idx_r;
      ram_wdata = word_r;
    end
  end

  olist_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // Next values of the request, pointer, count and result registers.
  always_comb begin
    cnt_nxt     = cnt_r;
    lim_nxt     = lim_r;
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    word_nxt    = word_r;
    addr_nxt    = addr_r;
    ok_nxt      = ok_r;
    removed_nxt = removed_r;
    found_nxt   = found_r;

    if (cfg_wr_en) begin
      lim_nxt = cfg_wr_data;
    end

    if (cmd.load) begin
      kind_nxt    = in_req.kind;
      idx_nxt     = IDX_W'(in_req.position - POS_W'(1));
      word_nxt    = DATA_WIDTH'(in_req.value);
      removed_nxt = '0;
      found_nxt   = '0;
      case (in_req.kind)
        KIND_INSERT: begin
          ok_nxt   = st.ins_ok;
          addr_nxt = last_idx;
        end
        KIND_DELETE: begin
          ok_nxt   = st.del_ok;
          addr_nxt = IDX_W'(in_req.position - POS_W'(1));
        end
        default: begin
          ok_nxt   = 1'b0;
          addr_nxt = '0;
        end
      endcase
    end

    if (cmd.step_up) begin
      addr_nxt = addr_r + IDX_W'(1);
    end else if (cmd.step_down) begin
      addr_nxt = addr_r - IDX_W'(1);
    end

    if (cmd.cap_removed) begin
      removed_nxt = VALUE_W'($signed(ram_rdata));
    end

    if (cmd.loc_check && st.match) begin
      ok_nxt    = 1'b1;
      found_nxt = POS_W'(prev_r) + POS_W'(1);
    end

    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lim_r <= LIMIT_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      lim_r <= lim_nxt;
    end
  end

  // Payload registers; prev_r tracks the address behind the read data.
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    idx_r     <= idx_nxt;
    word_r    <= word_nxt;
    addr_r    <= addr_nxt;
    prev_r    <= addr_r;
    ok_r      <= ok_nxt;
    removed_r <= removed_nxt;
    found_r   <= found_nxt;
  end

  // Result of the finished request.
  always_comb begin
    out_rsp.ok             = ok_r;
    out_rsp.removed_value  = (kind_r == KIND_DELETE) ? removed_r : '0;
    out_rsp.found_position = (kind_r == KIND_LOCATE) ? found_r : '0;
    out_rsp.list_length    = POS_W'(cnt_r);
  end

endmodule

// ===== bench/ordered_list_insert_delete_locate_tb.sv =====
module ordered_list_insert_delete_locate_tb;
  import olist_pkg::*;

  // The operation code that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Generous bound on the whole run, in clock cycles.
  localparam int RUN_LIMIT = 200000;

  // Running copy of the list: it applies each accepted request and queues the
  // response the block has to return for it.
  class list_mirror;
    logic signed [VALUE_W-1:0] entries [CAPACITY];
    int                        count;
    logic [LIM_W-1:0]          limit;
    out_rsp_t                  awaited_rsp [$];
    int                        errors;
    int                        taken;
    int                        checked;

    function new();
      count   = 0;
      limit   = LIMIT_RESET;
      errors  = 0;
      taken   = 0;
      checked = 0;
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void take_request(in_req_t r);
      out_rsp_t e;
      int       pos;
      int       lim;
      int       k;
      pos = int'(r.position);
      lim = (int'(limit) > CAPACITY) ? CAPACITY : int'(limit);
      e = '0;
      case (r.kind)
        KIND_INSERT: begin
          if (pos >= 1 && pos <= count + 1 && count < lim) begin
            for (k = count; k > pos - 1; k--) entries[k] = entries[k - 1];
            entries[pos - 1] = r.value;
            count++;
            e.ok = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (pos >= 1 && pos <= count) begin
            e.removed_value = entries[pos - 1];
            for (k = pos; k < count; k++) entries[k - 1] = entries[k];
            count--;
            e.ok = 1'b1;
          end
        end
        KIND_LOCATE: begin
          // Scan from the top so that the lowest match is the one kept.
          for (k = count - 1; k >= 0; k--) begin
            if (entries[k] == r.value) begin
              e.found_position = POS_W'(k + 1);
              e.ok = 1'b1;
            end
          end
        end
        default: ;
      endcase
      e.list_length = POS_W'(count);
      awaited_rsp.push_back(e);
      taken++;
    endfunction

    // Compare one accepted response with the oldest queued one.
    function void match_response(out_rsp_t got);
      out_rsp_t e;
      if (awaited_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = awaited_rsp.pop_front();
      checked++;
      if (got.ok !== e.ok) begin
        $error("ok expected %0d actual %0d", e.ok, got.ok);
        errors++;
      end
      if (got.removed_value !== e.removed_value) begin
        $error("removed_value expected %0d actual %0d", e.removed_value, got.removed_value);
        errors++;
      end
      if (got.found_position !== e.found_position) begin
        $error("found_position expected %0d actual %0d", e.found_position,
               got.found_position);
        errors++;
      end
      if (got.list_length !== e.list_length) begin
        $error("list_length expected %0d actual %0d", e.list_length, got.list_length);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_req_t          in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_rsp_t         out_rsp;
  logic             cfg_wr_en = 1'b0;
  logic [LIM_W-1:0] cfg_wr_data = '0;

  logic             calm_tail = 1'b0;
  int               stall_left = 0;
  int               cycle_count = 0;
  int               settings = 0;

  list_mirror mirror = new();

  ordered_list_insert_delete_locate u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Clock with a period of 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels and feed the mirror.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) mirror.take_request(in_req);
      if (out_valid && !out_stall) mirror.match_response(out_rsp);
    end
  end

  // Stall the response side in random bursts, except in the calm tail.
  always @(posedge clk) begin
    if (!rst_n || calm_tail) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL ordered_list_insert_delete_locate");
      $finish;
    end
  end

  // Offer one request, with an occasional idle gap first, and wait for it to be taken.
  task automatic push_request(in_req_t r);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(logic [KIND_W-1:0] kind, int pos, logic signed [VALUE_W-1:0] value);
    in_req_t r;
    r.kind     = kind;
    r.position = POS_W'(pos);
    r.value    = value;
    push_request(r);
  endtask

  // Stop offering requests and wait until every response has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.awaited_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Change the capacity limit while the block is idle.
  task automatic set_limit(int lim);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LIM_W'(lim);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    mirror.limit = LIM_W'(lim);
    settings++;
  endtask

  // Build a random request, mostly in range, with values often taken from the list.
  task automatic send_random(bit growing);
    in_req_t r;
    int      n;
    int      pick;
    n = mirror.count;
    pick = $urandom_range(0, 99);
    if (pick < 4) r.kind = KIND_UNUSED;
    else if (pick < 20) r.kind = KIND_LOCATE;
    else if (pick < (growing ? 80 : 45)) r.kind = KIND_INSERT;
    else r.kind = KIND_DELETE;

    if ($urandom_range(0, 9) == 0) r.position = POS_W'($urandom_range(0, 31));
    else if (r.kind == KIND_INSERT) r.position = POS_W'($urandom_range(1, n + 1));
    else if (n == 0) r.position = POS_W'(1);
    else r.position = POS_W'($urandom_range(1, n));

    r.value = $urandom;
    case ($urandom_range(0, 9))
      0: r.value = 32'sh8000_0000;
      1: r.value = 32'sh7fff_ffff;
      2: r.value = $urandom_range(0, 3);
      default: ;
    endcase
    // Reuse stored values for duplicates and for hits on locate.
    if (n > 0 && $urandom_range(0, 3) < ((r.kind == KIND_LOCATE) ? 3 : 1))
      r.value = mirror.entries[$urandom_range(0, n - 1)];
    push_request(r);
  endtask

  initial begin
    int phase_limits [10];
    int ph;
    int i;
    phase_limits = '{16, 3, 31, 1, 8, 0, 16, 2, 12, 16};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, bad positions, ends and middle of the list, duplicates.
    send_fields(KIND_LOCATE, 0, 0);
    send_fields(KIND_DELETE, 1, 0);
    send_fields(KIND_INSERT, 0, 11);
    send_fields(KIND_INSERT, 2, 12);
    send_fields(KIND_INSERT, 1, 32'sh8000_0000);
    send_fields(KIND_INSERT, 2, 32'sh7fff_ffff);
    send_fields(KIND_INSERT, 1, -1);
    send_fields(KIND_INSERT, 2, 0);
    send_fields(KIND_INSERT, 3, -1);
    send_fields(KIND_LOCATE, 0, -1);
    send_fields(KIND_LOCATE, 0, 32'sh7fff_ffff);
    send_fields(KIND_LOCATE, 0, 12345);
    send_fields(KIND_INSERT, 31, 5);
    send_fields(KIND_INSERT, 6, 7);
    send_fields(KIND_DELETE, 0, 0);
    send_fields(KIND_DELETE, 7, 0);
    send_fields(KIND_DELETE, 6, 0);
    send_fields(KIND_DELETE, 1, 0);
    send_fields(KIND_DELETE, 2, 0);
    send_fields(KIND_UNUSED, 1, 5);
    send_fields(KIND_DELETE, 31, 0);

    // Limit below the count, then a zero limit, then one above the store size.
    set_limit(2);
    send_fields(KIND_INSERT, 1, 21);
    send_fields(KIND_DELETE, 1, 0);
    send_fields(KIND_INSERT, 1, 22);
    set_limit(0);
    send_fields(KIND_INSERT, 1, 23);
    set_limit(31);
    send_fields(KIND_INSERT, 1, 24);

    // Random phases, each under its own limit, alternating growth and shrinkage.
    for (ph = 0; ph < 10; ph++) begin
      set_limit(phase_limits[ph]);
      if (ph == 9) calm_tail <= 1'b1;
      for (i = 0; i < 120; i++) send_random((i / 40) % 2 == 0);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests and checked %0d responses over %0d limit settings,",
             mirror.taken, mirror.checked, settings);
    $display("covering empty and full lists, bad positions, duplicates and limits 0 to 31.");
    if (mirror.errors == 0) begin
      $display("PASS ordered_list_insert_delete_locate");
    end else begin
      $display("FAIL ordered_list_insert_delete_locate");
    end
    $finish;
  end

endmodule
